// ===== rtl/core/assert_macros.svh =====
// assertion helpers used by bgr_engine
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define BGR_ASSERT_NOW(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("bgr assertion failed");

// next-cycle implication
`define BGR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("bgr assertion failed");

`endif

// ===== rtl/core/bgr_pkg.sv =====
package bgr_pkg;

  localparam int unsigned CfgWidth  = 16;
  localparam int unsigned TimeWidth = 32;
  localparam int unsigned CfgIdxWidth = 2;

  localparam logic [CfgIdxWidth-1:0] CFG_DEBOUNCE = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CFG_WINDOW   = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CFG_LONG     = 2'd2;

  localparam logic [CfgWidth-1:0] DebounceReset = 16'd20;
  localparam logic [CfgWidth-1:0] WindowReset   = 16'd300;
  localparam logic [CfgWidth-1:0] LongReset     = 16'd1000;

  typedef enum logic [1:0] {
    EV_NONE   = 2'd0,
    EV_SINGLE = 2'd1,
    EV_DOUBLE = 2'd2,
    EV_LONG   = 2'd3
  } event_e;

  typedef struct packed {
    logic [CfgWidth-1:0] debounce_time;
    logic [CfgWidth-1:0] double_click_window;
    logic [CfgWidth-1:0] long_press_time;
  } cfg_t;

endpackage

// ===== rtl/core/bgr_cfg_regs.sv =====
module bgr_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [bgr_pkg::CfgIdxWidth-1:0]      cfg_index_i,
  input  logic [bgr_pkg::CfgWidth-1:0]         cfg_wdata_i,
  output bgr_pkg::cfg_t                        cfg_o
);

  bgr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        bgr_pkg::CFG_DEBOUNCE: cfg_d.debounce_time       = cfg_wdata_i;
        bgr_pkg::CFG_WINDOW:   cfg_d.double_click_window = cfg_wdata_i;
        bgr_pkg::CFG_LONG:     cfg_d.long_press_time     = cfg_wdata_i;
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_time       <= bgr_pkg::DebounceReset;
      cfg_q.double_click_window <= bgr_pkg::WindowReset;
      cfg_q.long_press_time     <= bgr_pkg::LongReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bgr_engine.sv =====
`include "assert_macros.svh"

module bgr_engine (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bgr_pkg::cfg_t                      cfg_i,
  input  logic                               step_i,
  input  logic                               level_i,
  input  logic [bgr_pkg::TimeWidth-1:0]      now_i,
  output logic [1:0]                         event_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_FIRST  = 3'd1,
    PH_WAIT   = 3'd2,
    PH_SECOND = 3'd3,
    PH_LONG   = 3'd4
  } phase_e;

  localparam int unsigned TW = bgr_pkg::TimeWidth;
  localparam int unsigned PadW = TW - bgr_pkg::CfgWidth;

  logic            seen_q, seen_d;
  logic            raw_q, raw_d;
  logic            stable_q, stable_d;
  logic [TW-1:0]   rct_q, rct_d;
  phase_e          phase_q, phase_d;
  logic [TW-1:0]   pst_q, pst_d;
  logic [TW-1:0]   frt_q, frt_d;
  bgr_pkg::event_e ev_d;

  logic          raw_chg;
  logic          stable_edge;
  logic          pst_upd;
  logic          frt_upd;
  logic [TW-1:0] deb_el;
  logic [TW-1:0] gap_el;
  logic [TW-1:0] press_el;
  logic [TW-1:0] rel_el;
  logic [TW-1:0] deb_ext;
  logic [TW-1:0] win_ext;
  logic [TW-1:0] long_ext;

  assign deb_ext  = {{PadW{1'b0}}, cfg_i.debounce_time};
  assign win_ext  = {{PadW{1'b0}}, cfg_i.double_click_window};
  assign long_ext = {{PadW{1'b0}}, cfg_i.long_press_time};

  assign raw_chg     = level_i != raw_q;
  assign deb_el      = raw_chg ? '0 : now_i - rct_q;
  assign gap_el      = now_i - frt_q;
  assign stable_edge = (level_i != stable_q) && (deb_el >= deb_ext);

  always_comb begin
    seen_d   = seen_q;
    raw_d    = raw_q;
    stable_d = stable_q;
    rct_d    = rct_q;
    phase_d  = phase_q;
    pst_d    = pst_q;
    frt_d    = frt_q;
    ev_d     = bgr_pkg::EV_NONE;
    pst_upd  = 1'b0;
    frt_upd  = 1'b0;
    press_el = '0;
    rel_el   = '0;
    if (!seen_q) begin
      // baseline sample
      seen_d   = 1'b1;
      raw_d    = level_i;
      stable_d = level_i;
      rct_d    = now_i;
      if (level_i) begin
        phase_d = PH_FIRST;
        pst_d   = now_i;
      end else begin
        phase_d = PH_IDLE;
      end
    end else begin
      raw_d = level_i;
      if (raw_chg) begin
        rct_d = now_i;
      end
      if (stable_edge) begin
        stable_d = level_i;
        if (level_i) begin
          case (phase_q)
            PH_IDLE: begin
              phase_d = PH_FIRST;
              pst_upd = 1'b1;
            end
            PH_WAIT: begin
              if (gap_el <= win_ext) begin
                phase_d = PH_SECOND;
              end else begin
                phase_d = PH_FIRST;
                ev_d    = bgr_pkg::EV_SINGLE;
              end
              pst_upd = 1'b1;
            end
            default: phase_d = phase_q;
          endcase
        end else begin
          case (phase_q)
            PH_FIRST: begin
              phase_d = PH_WAIT;
              frt_upd = 1'b1;
            end
            PH_SECOND: begin
              phase_d = PH_IDLE;
              ev_d    = bgr_pkg::EV_DOUBLE;
            end
            PH_LONG: phase_d = PH_IDLE;
            default: phase_d = phase_q;
          endcase
        end
      end
      if (pst_upd) begin
        pst_d = now_i;
      end
      if (frt_upd) begin
        frt_d = now_i;
      end
      // timeouts, measured from the times as they stand after the edge
      press_el = pst_upd ? '0 : now_i - pst_q;
      rel_el   = frt_upd ? '0 : gap_el;
      if (ev_d == bgr_pkg::EV_NONE) begin
        if ((phase_d == PH_FIRST || phase_d == PH_SECOND) && press_el >= long_ext) begin
          phase_d = PH_LONG;
          ev_d    = bgr_pkg::EV_LONG;
        end else if (phase_d == PH_WAIT && !level_i && rel_el > win_ext) begin
          phase_d = PH_IDLE;
          ev_d    = bgr_pkg::EV_SINGLE;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q   <= 1'b0;
      raw_q    <= 1'b0;
      stable_q <= 1'b0;
      rct_q    <= '0;
      phase_q  <= PH_IDLE;
      pst_q    <= '0;
      frt_q    <= '0;
    end else if (step_i) begin
      seen_q   <= seen_d;
      raw_q    <= raw_d;
      stable_q <= stable_d;
      rct_q    <= rct_d;
      phase_q  <= phase_d;
      pst_q    <= pst_d;
      frt_q    <= frt_d;
    end
  end

  assign event_o = ev_d;

  `BGR_ASSERT_NOW(a_baseline_quiet, clk_i, rst_ni, step_i && !seen_q, ev_d == bgr_pkg::EV_NONE)
  `BGR_ASSERT_NOW(a_double_from_second, clk_i, rst_ni, step_i && ev_d == bgr_pkg::EV_DOUBLE,
                  phase_q == PH_SECOND)
  `BGR_ASSERT_NEXT(a_long_enters_hold, clk_i, rst_ni, step_i && ev_d == bgr_pkg::EV_LONG,
                   phase_q == PH_LONG)

endmodule

// ===== rtl/core/button_gesture_recognizer_top.sv =====
// Debounced button gesture recognizer: each sample word (level plus millisecond
// timestamp) yields exactly one result word, 0 none, 1 single click, 2 double
// click, 3 long press. A sample passes an input register, is evaluated against
// the gesture state and lands in an output register, so a result word is valid
// once its sample has moved from the input register into the output register;
// one sample is taken every cycle while the output register is empty or being
// read. The user must write timing registers through the config port only
// while no sample is in flight; the block itself does not enforce this.
module button_gesture_recognizer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                button_pressed_i,
  input  logic [bgr_pkg::TimeWidth-1:0]       now_time_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [1:0]                          gesture_event_o,
  input  logic                                cfg_we_i,
  input  logic [bgr_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [bgr_pkg::CfgWidth-1:0]        cfg_wdata_i
);

  bgr_pkg::cfg_t cfg;

  logic                             s1_valid_q;
  logic                             s1_level_q;
  logic [bgr_pkg::TimeWidth-1:0]    s1_time_q;
  logic                             out_valid_q;
  logic [1:0]                       out_event_q;
  logic                             advance;
  logic                             in_fire;
  logic [1:0]                       step_event;

  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  bgr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bgr_engine u_engine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .step_i  (advance),
    .level_i (s1_level_q),
    .now_i   (s1_time_q),
    .event_o (step_event)
  );

  // input word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_level_q <= button_pressed_i;
      s1_time_q  <= now_time_i;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_event_q <= step_event;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gesture_event_o = out_event_q;

endmodule
